/* rtl/dhrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhrp_pkg
// Shared constants, codes and types of the dual H-bridge ramp PWM core.
// ----------------------------------------------------------------------------
package dhrp_pkg;

  // Motors fitted (1..2); the port set always carries two motor slots.
  localparam int NUM_MOTORS  = 2;
  localparam int MOTOR_SLOTS = 2;

  // Config register indexes
  localparam logic [0:0] REG_STEP_SIZE  = 1'd0;
  localparam logic [0:0] REG_PWM_PERIOD = 1'd1;

  // Command codes
  localparam logic [1:0] CMD_SET_TARGET = 2'd0;
  localparam logic [1:0] CMD_STOP       = 2'd1;
  localparam logic [1:0] CMD_RAMP       = 2'd2;
  localparam logic [1:0] CMD_LIMIT      = 2'd3;

  // Direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  // Per-motor compare actions handed down the pipe
  localparam logic [1:0] ACT_KEEP = 2'd0;
  localparam logic [1:0] ACT_ZERO = 2'd1;
  localparam logic [1:0] ACT_LOAD = 2'd2;

  // Register resets and limits
  localparam logic [3:0]  STEP_RESET     = 4'd2;
  localparam logic [3:0]  STEP_MIN       = 4'd1;
  localparam logic [3:0]  STEP_MAX       = 4'd10;
  localparam logic [15:0] PERIOD_RESET   = 16'd999;
  localparam logic [9:0]  PERIOD_Q_RESET = 10'd9;   // 999 / 100

  localparam logic signed [7:0] SPEED_MAX = 8'sd100;
  localparam logic signed [7:0] SPEED_MIN = -8'sd100;

  // Reciprocals of 100: exact for a 16-bit period and for a remainder product < 10000
  localparam logic [16:0] RECIP_P       = 17'd83887;
  localparam int          RECIP_P_SHIFT = 23;
  localparam logic [12:0] RECIP_R       = 13'd5243;
  localparam int          RECIP_R_SHIFT = 19;

  // Result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0] code;
    logic       neg;
    logic [6:0] mag;
  } act_t;

  typedef struct packed {
    logic [3:0][15:0] cmp;   // motor*2 + leg, leg 0 forward
    logic [1:0][7:0]  spd;
    logic [1:0][1:0]  dir;
  } result_t;

  function automatic logic [1:0] sign_code(input logic signed [7:0] v);
    logic [1:0] code;
    code = DIR_STOP;
    if (v > 8'sd0) begin
      code = DIR_FWD;
    end else if (v < 8'sd0) begin
      code = DIR_REV;
    end
    return code;
  endfunction

endpackage

/* rtl/dual_hbridge_ramp_pwm_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_hbridge_ramp_pwm_core
// Two-motor H-bridge speed ramp with per-leg PWM compare generation.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  config   | cfg_we                 | cfg_idx, cfg_wdata
//  command  | cmd_valid / cmd_stall  | cmd, motor_select, target_percent, limits
//  result   | res_valid / res_stall  | compares, speeds, directions
//
//  One command transaction per cycle while cmd_stall is low. A result passes
//  through the speed/goal/direction update at accept, then the |speed| x
//  period multiply, then the divide-by-100 correction and compare update.
//  A four-entry result queue decouples the two sides; cmd_stall rises only
//  when the queue plus the two in-flight stages would overflow it.
//  rst is synchronous: all speeds, goals, directions, compares and the
//  queue clear; step_size returns to 2 and pwm_period to 999.
//
module dual_hbridge_ramp_pwm_core (
  input  logic              clk,
  input  logic              rst,
  // config write port
  input  logic              cfg_we,
  input  logic [0:0]        cfg_idx,
  input  logic [15:0]       cfg_wdata,
  // command channel
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  logic [1:0]        cmd,
  input  logic              motor_select,
  input  logic signed [7:0] target_percent,
  input  logic              fwd_limit_a_n,
  input  logic              fwd_limit_b_n,
  input  logic              rev_limit_n,
  input  logic              estop_n,
  // result channel
  output logic              res_valid,
  input  logic              res_stall,
  output logic [15:0]       fwd_compare_m1,
  output logic [15:0]       rev_compare_m1,
  output logic [15:0]       fwd_compare_m2,
  output logic [15:0]       rev_compare_m2,
  output logic signed [7:0] speed_m1,
  output logic signed [7:0] speed_m2,
  output logic [1:0]        dir_m1,
  output logic [1:0]        dir_m2
);
  import dhrp_pkg::*;

  // --------------------------------------------------------------------------
  // Config registers. The period is kept also as its quotient by 100; the
  // remainder follows from the two, so |speed|*period/100 needs only narrow
  // products later.
  // --------------------------------------------------------------------------
  logic [3:0]  step_size;
  logic [15:0] pwm_period;
  logic [9:0]  period_q;
  logic [6:0]  period_r;
  logic [32:0] q_prod;
  logic [16:0] q_times_100;

  assign q_prod      = 33'(cfg_wdata) * 33'(RECIP_P);
  assign q_times_100 = 17'(period_q) * 17'd100;
  assign period_r    = 7'(pwm_period - q_times_100[15:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size  <= STEP_RESET;
      pwm_period <= PERIOD_RESET;
      period_q   <= PERIOD_Q_RESET;
    end else begin
      if (cfg_we && cfg_idx == REG_STEP_SIZE &&
          cfg_wdata[3:0] >= STEP_MIN && cfg_wdata[3:0] <= STEP_MAX) begin
        step_size <= cfg_wdata[3:0];
      end
      if (cfg_we && cfg_idx == REG_PWM_PERIOD) begin
        pwm_period <= cfg_wdata;
        period_q   <= q_prod[RECIP_P_SHIFT+9:RECIP_P_SHIFT];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: motor state update at accept
  // --------------------------------------------------------------------------
  logic cmd_acc;
  assign cmd_acc = cmd_valid && !cmd_stall;

  logic signed [7:0] speed    [MOTOR_SLOTS];
  logic signed [7:0] goal     [MOTOR_SLOTS];
  logic [1:0]        dir      [MOTOR_SLOTS];
  logic signed [7:0] speed_next[MOTOR_SLOTS];
  logic signed [7:0] goal_next[MOTOR_SLOTS];
  logic [1:0]        dir_next [MOTOR_SLOTS];
  act_t              act_next [MOTOR_SLOTS];
  logic signed [8:0] ramp_up  [MOTOR_SLOTS];
  logic signed [8:0] ramp_dn  [MOTOR_SLOTS];
  logic signed [7:0] ramp_nxt [MOTOR_SLOTS];
  logic              limit_hit[MOTOR_SLOTS];
  logic signed [7:0] tgt_clamp;

  assign tgt_clamp = (target_percent > SPEED_MAX) ? SPEED_MAX :
                     (target_percent < SPEED_MIN) ? SPEED_MIN : target_percent;

  always_comb begin
    for (int m = 0; m < MOTOR_SLOTS; m++) begin
      // one step toward the goal, never past it
      ramp_up[m] = 9'(speed[m]) + $signed({5'b0, step_size});
      ramp_dn[m] = 9'(speed[m]) - $signed({5'b0, step_size});
      if (goal[m] > speed[m]) begin
        ramp_nxt[m] = (ramp_up[m] > 9'(goal[m])) ? goal[m] : 8'(ramp_up[m]);
      end else begin
        ramp_nxt[m] = (ramp_dn[m] < 9'(goal[m])) ? goal[m] : 8'(ramp_dn[m]);
      end
      // travel limit in the direction of motion, or e-stop
      limit_hit[m] = !estop_n ||
                     ((speed[m] > 8'sd0) ? (!fwd_limit_a_n || !fwd_limit_b_n)
                                         : !rev_limit_n);

      speed_next[m] = speed[m];
      goal_next[m]  = goal[m];
      dir_next[m]   = dir[m];
      act_next[m]   = '{code: ACT_KEEP, neg: 1'b0, mag: 7'd0};

      if (m < NUM_MOTORS) begin
        case (cmd)
          CMD_SET_TARGET: begin
            if (int'(motor_select) == m) begin
              goal_next[m] = tgt_clamp;
              dir_next[m]  = sign_code(tgt_clamp);
            end
          end
          CMD_STOP: begin
            if (int'(motor_select) == m) begin
              speed_next[m]    = 8'sd0;
              goal_next[m]     = 8'sd0;
              dir_next[m]      = DIR_STOP;
              act_next[m].code = ACT_ZERO;
            end
          end
          CMD_RAMP: begin
            // a motor already at its goal keeps compares and direction
            if (speed[m] != goal[m]) begin
              speed_next[m]    = ramp_nxt[m];
              dir_next[m]      = sign_code(ramp_nxt[m]);
              act_next[m].code = ACT_LOAD;
              act_next[m].neg  = ramp_nxt[m][7];
              act_next[m].mag  = ramp_nxt[m][7] ? 7'(-ramp_nxt[m]) : ramp_nxt[m][6:0];
            end
          end
          CMD_LIMIT: begin
            // a motor at rest is skipped, even with a nonzero goal
            if (speed[m] != 8'sd0 && limit_hit[m]) begin
              speed_next[m]    = 8'sd0;
              goal_next[m]     = 8'sd0;
              dir_next[m]      = DIR_STOP;
              act_next[m].code = ACT_ZERO;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < MOTOR_SLOTS; m++) begin
        speed[m] <= 8'sd0;
        goal[m]  <= 8'sd0;
        dir[m]   <= DIR_STOP;
      end
    end else if (cmd_acc) begin
      for (int m = 0; m < MOTOR_SLOTS; m++) begin
        speed[m] <= speed_next[m];
        goal[m]  <= goal_next[m];
        dir[m]   <= dir_next[m];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 -> 2: compare actions and the state snapshot travel with the
  // transaction so later compare writes land in command order.
  // --------------------------------------------------------------------------
  logic              s1_valid;
  act_t              s1_act[MOTOR_SLOTS];
  logic [1:0][7:0]   s1_spd;
  logic [1:0][1:0]   s1_dir;

  logic              s2_valid;
  logic [1:0]        s2_code[MOTOR_SLOTS];
  logic              s2_neg [MOTOR_SLOTS];
  logic [16:0]       s2_mq  [MOTOR_SLOTS];
  logic [13:0]       s2_mr  [MOTOR_SLOTS];
  logic [1:0][7:0]   s2_spd;
  logic [1:0][1:0]   s2_dir;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd_acc;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int m = 0; m < MOTOR_SLOTS; m++) begin
      s1_act[m] <= act_next[m];
      s1_spd[m] <= speed_next[m];
      s1_dir[m] <= dir_next[m];
      // |speed| * period = |speed|*q*100 + |speed|*r
      s2_code[m] <= s1_act[m].code;
      s2_neg[m]  <= s1_act[m].neg;
      s2_mq[m]   <= 17'(s1_act[m].mag) * 17'(period_q);
      s2_mr[m]   <= 14'(s1_act[m].mag) * 14'(period_r);
    end
    s2_spd <= s1_spd;
    s2_dir <= s1_dir;
  end

  // --------------------------------------------------------------------------
  // Stage 2: finish the /100 and update the leg compares
  // --------------------------------------------------------------------------
  logic [3:0][15:0] cmp;
  logic [3:0][15:0] cmp_next;
  logic [26:0]      mr_prod[MOTOR_SLOTS];
  logic [16:0]      pulse  [MOTOR_SLOTS];

  always_comb begin
    cmp_next = cmp;
    for (int m = 0; m < MOTOR_SLOTS; m++) begin
      mr_prod[m] = 27'(s2_mr[m]) * 27'(RECIP_R);
      pulse[m]   = s2_mq[m] + 17'(mr_prod[m] >> RECIP_R_SHIFT);
      case (s2_code[m])
        ACT_ZERO: begin
          cmp_next[2*m]   = 16'd0;
          cmp_next[2*m+1] = 16'd0;
        end
        ACT_LOAD: begin
          cmp_next[2*m]   = s2_neg[m] ? 16'd0 : pulse[m][15:0];
          cmp_next[2*m+1] = s2_neg[m] ? pulse[m][15:0] : 16'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp <= '0;
    end else if (s2_valid) begin
      cmp <= cmp_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  result_t             queue[QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                push;
  logic                pop;
  logic [QUEUE_AW+1:0] pending;
  result_t             head;

  assign push    = s2_valid;
  assign pop     = res_valid && !res_stall;
  assign pending = (QUEUE_AW+2)'(count) + (QUEUE_AW+2)'(s1_valid) +
                   (QUEUE_AW+2)'(s2_valid);
  assign cmd_stall = pending >= (QUEUE_AW+2)'(QUEUE_DEPTH);
  assign res_valid = count != '0;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{cmp: cmp_next, spd: s2_spd, dir: s2_dir};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head           = queue[rd_ptr];
  assign fwd_compare_m1 = head.cmp[0];
  assign rev_compare_m1 = head.cmp[1];
  assign fwd_compare_m2 = head.cmp[2];
  assign rev_compare_m2 = head.cmp[3];
  assign speed_m1       = $signed(head.spd[0]);
  assign speed_m2       = $signed(head.spd[1]);
  assign dir_m1         = head.dir[0];
  assign dir_m2         = head.dir[1];

endmodule

/* rtl/dhrp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhrp_checker
// Port-level checks of the dual H-bridge ramp PWM core.
// ----------------------------------------------------------------------------
module dhrp_checker (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_stall,
  input logic [15:0]       fwd_compare_m1,
  input logic [15:0]       rev_compare_m1,
  input logic [15:0]       fwd_compare_m2,
  input logic [15:0]       rev_compare_m2,
  input logic signed [7:0] speed_m1,
  input logic signed [7:0] speed_m2,
  input logic [1:0]        dir_m1,
  input logic [1:0]        dir_m2
);
  import dhrp_pkg::*;

  // queue empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(speed_m1) && $stable(speed_m2) &&
      $stable(fwd_compare_m1) && $stable(rev_compare_m1) &&
      $stable(fwd_compare_m2) && $stable(rev_compare_m2) &&
      $stable(dir_m1) && $stable(dir_m2))
    else $error("stalled result changed");

  // at most one bridge leg driven per motor
  a_one_leg: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (fwd_compare_m1 == 16'd0 || rev_compare_m1 == 16'd0) &&
                  (fwd_compare_m2 == 16'd0 || rev_compare_m2 == 16'd0))
    else $error("both legs driven");

  // a motor at rest drives neither leg
  a_rest_off: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (speed_m1 != 8'sd0 || (fwd_compare_m1 == 16'd0 && rev_compare_m1 == 16'd0)) &&
                  (speed_m2 != 8'sd0 || (fwd_compare_m2 == 16'd0 && rev_compare_m2 == 16'd0)))
    else $error("compare set on idle motor");

  // speeds stay within the clamp range, directions are legal codes
  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> speed_m1 >= SPEED_MIN && speed_m1 <= SPEED_MAX &&
                  speed_m2 >= SPEED_MIN && speed_m2 <= SPEED_MAX &&
                  (dir_m1 == DIR_STOP || dir_m1 == DIR_FWD || dir_m1 == DIR_REV) &&
                  (dir_m2 == DIR_STOP || dir_m2 == DIR_FWD || dir_m2 == DIR_REV))
    else $error("speed or direction out of range");

endmodule

bind dual_hbridge_ramp_pwm_core dhrp_checker u_dhrp_checker (.*);

/* tb/tb_dual_hbridge_ramp_pwm_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_hbridge_ramp_pwm_core
// Self-checking bench for the two-motor ramp / H-bridge compare core.
// A short directed table covers reset values, clamping, every command and
// the limit-switch corner cases. Seven register phases follow, with random
// command streams. A cycle-free predictor of the motor state produces the
// expected result for every accepted command. Results are checked in
// order against it while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_dual_hbridge_ramp_pwm_core;
  import dhrp_pkg::*;

  // Limit switch bundle order in a row: {fwd_a_n, fwd_b_n, rev_n, estop_n}
  localparam logic [3:0] SW_OPEN = 4'b1111;
  localparam logic [3:0] SW_FA   = 4'b0111;
  localparam logic [3:0] SW_FB   = 4'b1011;
  localparam logic [3:0] SW_RV   = 4'b1101;
  localparam logic [3:0] SW_ES   = 4'b1110;
  localparam logic [3:0] SW_FWDS = 4'b0011;   // both forward limits hit
  localparam logic [3:0] SW_ALL  = 4'b0000;

  localparam int DIRECTED_ROWS  = 26;
  localparam int NUM_PHASES     = 7;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int SQUEEZE_CYCLES = 400;     // long result hold-off
  localparam int IDLE_LIMIT     = 2000;    // cycles without any transaction
  localparam int SETTLE_CYCLES  = 8;       // pipeline is three deep

  typedef struct {
    logic [1:0]        op;
    logic              sel;
    logic signed [7:0] pct;
    logic [3:0]        sw;
    bit                typed;   // want holds a hand-written expectation
    result_t           want;
  } row_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_idx = REG_STEP_SIZE;
  logic [15:0]       cfg_wdata = '0;
  logic              cmd_valid = 1'b0;
  logic              cmd_stall;
  logic [1:0]        cmd = CMD_SET_TARGET;
  logic              motor_select = 1'b0;
  logic signed [7:0] target_percent = '0;
  logic              fwd_limit_a_n = 1'b1;
  logic              fwd_limit_b_n = 1'b1;
  logic              rev_limit_n = 1'b1;
  logic              estop_n = 1'b1;
  logic              res_valid;
  logic              res_stall = 1'b0;
  logic [15:0]       fwd_compare_m1, rev_compare_m1;
  logic [15:0]       fwd_compare_m2, rev_compare_m2;
  logic signed [7:0] speed_m1, speed_m2;
  logic [1:0]        dir_m1, dir_m2;

  dual_hbridge_ramp_pwm_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .cmd            (cmd),
    .motor_select   (motor_select),
    .target_percent (target_percent),
    .fwd_limit_a_n  (fwd_limit_a_n),
    .fwd_limit_b_n  (fwd_limit_b_n),
    .rev_limit_n    (rev_limit_n),
    .estop_n        (estop_n),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .fwd_compare_m1 (fwd_compare_m1),
    .rev_compare_m1 (rev_compare_m1),
    .fwd_compare_m2 (fwd_compare_m2),
    .rev_compare_m2 (rev_compare_m2),
    .speed_m1       (speed_m1),
    .speed_m2       (speed_m2),
    .dir_m1         (dir_m1),
    .dir_m2         (dir_m2)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Motor state mirror: speeds and goals kept as plain ints, compares at the
  // 16-bit width of the ports.
  // --------------------------------------------------------------------------
  int          ramp_speed [2];
  int          goal_speed [2];
  logic [1:0]  motor_dir [2];
  logic [15:0] leg_cmp [4];    // motor*2 + leg, leg 0 forward
  logic [3:0]  step_reg;
  logic [15:0] period_reg;

  result_t drive_expect_q [$];
  int      err_count = 0;
  int      burst_left = 0;
  bit      squeeze_go = 1'b0;
  bit      squeeze_done = 1'b0;
  row_t    dir_tab [DIRECTED_ROWS];

  function automatic logic [1:0] dir_of(input int v);
    if (v > 0) return DIR_FWD;
    if (v < 0) return DIR_REV;
    return DIR_STOP;
  endfunction

  function automatic void halt_slot(input int m);
    ramp_speed[m] = 0;
    goal_speed[m] = 0;
    motor_dir[m] = DIR_STOP;
    leg_cmp[m*2] = '0;
    leg_cmp[m*2+1] = '0;
  endfunction

  function automatic void clear_drive_state();
    step_reg = STEP_RESET;
    period_reg = PERIOD_RESET;
    halt_slot(0);
    halt_slot(1);
  endfunction

  // Applies one command to the mirror and returns the post-command snapshot
  function automatic result_t next_drive_state(input row_t r);
    result_t res;
    int      m, pct, cur, nxt, mag, pulse;
    logic    hit;
    pct = r.pct;
    case (r.op)
      CMD_SET_TARGET: begin
        if (pct > 100) pct = 100;
        if (pct < -100) pct = -100;
        goal_speed[r.sel] = pct;
        // direction follows the new goal at once, compares wait for a ramp
        motor_dir[r.sel] = dir_of(pct);
      end
      CMD_STOP: begin
        halt_slot(r.sel);
      end
      CMD_RAMP: begin
        for (m = 0; m < NUM_MOTORS; m++) begin
          cur = ramp_speed[m];
          if (cur != goal_speed[m]) begin
            if (goal_speed[m] > cur) begin
              nxt = cur + int'(step_reg);
              if (nxt > goal_speed[m]) nxt = goal_speed[m];
            end else begin
              nxt = cur - int'(step_reg);
              if (nxt < goal_speed[m]) nxt = goal_speed[m];
            end
            mag = (nxt < 0) ? -nxt : nxt;
            pulse = (mag * int'(period_reg)) / 100;
            leg_cmp[m*2]   = (nxt > 0) ? 16'(pulse) : 16'd0;
            leg_cmp[m*2+1] = (nxt < 0) ? 16'(pulse) : 16'd0;
            motor_dir[m] = dir_of(nxt);
            ramp_speed[m] = nxt;
          end
        end
      end
      default: begin
        // limit tick; a motor at rest is skipped even with a goal pending
        for (m = 0; m < NUM_MOTORS; m++) begin
          cur = ramp_speed[m];
          if (cur != 0) begin
            if (cur > 0) hit = !r.sw[3] || !r.sw[2];
            else hit = !r.sw[1];
            if (!r.sw[0]) hit = 1'b1;
            if (hit) halt_slot(m);
          end
        end
      end
    endcase
    for (m = 0; m < 4; m++) res.cmp[m] = leg_cmp[m];
    for (m = 0; m < 2; m++) begin
      res.spd[m] = 8'(ramp_speed[m]);
      res.dir[m] = motor_dir[m];
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Table helpers
  // --------------------------------------------------------------------------
  function automatic row_t row(input logic [1:0] op, input logic sel, input int pct,
                               input logic [3:0] sw);
    row_t r;
    r.op = op;
    r.sel = sel;
    r.pct = 8'(pct);
    r.sw = sw;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t chk(input row_t r, input result_t want);
    row_t t;
    t = r;
    t.typed = 1'b1;
    t.want = want;
    return t;
  endfunction

  function automatic result_t pack_res(input int c0, input int c1, input int c2, input int c3,
                                       input int s0, input int s1,
                                       input logic [1:0] d0, input logic [1:0] d1);
    result_t res;
    res.cmp[0] = 16'(c0);
    res.cmp[1] = 16'(c1);
    res.cmp[2] = 16'(c2);
    res.cmp[3] = 16'(c3);
    res.spd[0] = 8'(s0);
    res.spd[1] = 8'(s1);
    res.dir[0] = d0;
    res.dir[1] = d1;
    return res;
  endfunction

  // Random command: ramps dominate so motors actually get up to speed,
  // limit switches are mostly released so limit ticks do not halt everything.
  function automatic row_t rand_row();
    row_t       r;
    int         pick, pct;
    logic [3:0] sw;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 6))
          0: pct = 127;
          1: pct = -128;
          2: pct = 100;
          3: pct = -100;
          4: pct = 101;
          5: pct = -101;
          default: pct = 0;
        endcase
      end
      1, 2: pct = int'($urandom_range(0, 200)) - 100;
      default: pct = int'($urandom_range(0, 255)) - 128;
    endcase
    sw = SW_OPEN;
    for (int b = 0; b < 4; b++) begin
      if ($urandom_range(0, 7) == 0) sw[b] = 1'b0;
    end
    if (pick < 30) r = row(CMD_SET_TARGET, 1'($urandom_range(0, 1)), pct, sw);
    else if (pick < 38) r = row(CMD_STOP, 1'($urandom_range(0, 1)), pct, sw);
    else if (pick < 80) r = row(CMD_RAMP, 1'($urandom_range(0, 1)), pct, sw);
    else r = row(CMD_LIMIT, 1'($urandom_range(0, 1)), pct, sw);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic log_error(input string msg);
    if (err_count < 40) $display("%0t ERROR %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      log_error($sformatf("%s: got 0x%04h, want 0x%04h", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Command sender: bursts of random length, random gaps between them.
  // The payload is held until the transaction goes through.
  // --------------------------------------------------------------------------
  task automatic issue(input row_t r);
    result_t want;
    int      gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    cmd_valid      <= 1'b1;
    cmd            <= r.op;
    motor_select   <= r.sel;
    target_percent <= r.pct;
    fwd_limit_a_n  <= r.sw[3];
    fwd_limit_b_n  <= r.sw[2];
    rev_limit_n    <= r.sw[1];
    estop_n        <= r.sw[0];
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    // transaction accepted at this edge
    want = next_drive_state(r);
    if (r.typed) want = r.want;
    drive_expect_q.push_back(want);
  endtask

  // Both registers, back to back, only with the core drained
  task automatic program_regs(input logic [15:0] step_w, input logic [15:0] period_w);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_STEP_SIZE;
    cfg_wdata <= step_w;
    @(posedge clk);
    cfg_idx   <= REG_PWM_PERIOD;
    cfg_wdata <= period_w;
    @(posedge clk);
    cfg_we <= 1'b0;
    // only the low nibble reaches the step register; out-of-range is dropped
    if (step_w[3:0] >= STEP_MIN && step_w[3:0] <= STEP_MAX) step_reg = step_w[3:0];
    period_reg = period_w;
  endtask

  task automatic drain();
    while (drive_expect_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: checker and stall pattern
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (drive_expect_q.size() == 0) begin
        log_error("result transaction with nothing expected");
      end else begin
        want = drive_expect_q.pop_front();
        check_field("fwd_compare_m1", fwd_compare_m1, want.cmp[0]);
        check_field("rev_compare_m1", rev_compare_m1, want.cmp[1]);
        check_field("fwd_compare_m2", fwd_compare_m2, want.cmp[2]);
        check_field("rev_compare_m2", rev_compare_m2, want.cmp[3]);
        // speeds compared as raw 8-bit patterns
        check_field("speed_m1", {8'd0, speed_m1}, {8'd0, want.spd[0]});
        check_field("speed_m2", {8'd0, speed_m2}, {8'd0, want.spd[1]});
        check_field("dir_m1", 16'(dir_m1), 16'(want.dir[0]));
        check_field("dir_m2", 16'(dir_m2), 16'(want.dir[1]));
      end
    end
  end

  // Stall pattern in spans: free-running, coin flip, mostly stalled,
  // alternating. Once, a long hold-off so the queue fills and cmd_stall rises.
  initial begin : rx_pacing
    int mode, span, k;
    forever begin
      if (squeeze_go && !squeeze_done) begin
        res_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 64);
        for (k = 0; k < span; k++) begin
          case (mode)
            0: res_stall <= 1'b0;
            1: res_stall <= ($urandom_range(0, 1) == 1);
            2: res_stall <= ($urandom_range(0, 3) != 0);
            default: res_stall <= k[0];
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
        idle = 0;
      else
        idle++;
    end
    $display("tb_dual_hbridge_ramp_pwm_core: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int          ph, n;
    logic [15:0] step_w, period_w;

    clear_drive_state();

    // Directed table, reset register values (step 2, period 999).
    // 2% of 999 -> 19 on the active leg.
    dir_tab[0]  = chk(row(CMD_RAMP, 0, 0, SW_OPEN),
                      pack_res(0, 0, 0, 0, 0, 0, DIR_STOP, DIR_STOP));
    // clamp of the positive and negative extremes, direction set at once
    dir_tab[1]  = chk(row(CMD_SET_TARGET, 0, 127, SW_OPEN),
                      pack_res(0, 0, 0, 0, 0, 0, DIR_FWD, DIR_STOP));
    dir_tab[2]  = chk(row(CMD_SET_TARGET, 1, -128, SW_OPEN),
                      pack_res(0, 0, 0, 0, 0, 0, DIR_FWD, DIR_REV));
    dir_tab[3]  = chk(row(CMD_RAMP, 0, 0, SW_OPEN),
                      pack_res(19, 0, 0, 19, 2, -2, DIR_FWD, DIR_REV));
    // limit tick with everything released: no change
    dir_tab[4]  = chk(row(CMD_LIMIT, 1, -1, SW_OPEN),
                      pack_res(19, 0, 0, 19, 2, -2, DIR_FWD, DIR_REV));
    // reverse limit only hits the motor running in reverse
    dir_tab[5]  = chk(row(CMD_LIMIT, 0, 0, SW_RV),
                      pack_res(19, 0, 0, 0, 2, 0, DIR_FWD, DIR_STOP));
    dir_tab[6]  = chk(row(CMD_LIMIT, 0, 0, SW_FA),
                      pack_res(0, 0, 0, 0, 0, 0, DIR_STOP, DIR_STOP));
    dir_tab[7]  = row(CMD_SET_TARGET, 0, 100, SW_OPEN);
    dir_tab[8]  = row(CMD_SET_TARGET, 1, -100, SW_OPEN);
    dir_tab[9]  = row(CMD_RAMP, 1, 0, SW_OPEN);
    dir_tab[10] = row(CMD_RAMP, 0, 0, SW_ALL);
    dir_tab[11] = row(CMD_LIMIT, 0, 0, SW_FB);
    dir_tab[12] = row(CMD_LIMIT, 1, 0, SW_ES);
    // small reverse goal: ramp stops at the goal, then a tick at goal is a no-op
    dir_tab[13] = row(CMD_SET_TARGET, 0, -1, SW_OPEN);
    dir_tab[14] = row(CMD_RAMP, 0, 0, SW_OPEN);
    dir_tab[15] = row(CMD_RAMP, 0, 0, SW_OPEN);
    // forward limits do not touch a reverse mover; all asserted does
    dir_tab[16] = row(CMD_LIMIT, 0, 0, SW_FWDS);
    dir_tab[17] = row(CMD_LIMIT, 0, 0, SW_ALL);
    // idle motor with a pending goal survives the emergency stop tick
    dir_tab[18] = row(CMD_SET_TARGET, 1, 30, SW_OPEN);
    dir_tab[19] = row(CMD_LIMIT, 1, 0, SW_ES);
    dir_tab[20] = row(CMD_RAMP, 1, 0, SW_OPEN);
    // zero goal on a mover: direction drops now, compares at the next ramp
    dir_tab[21] = row(CMD_SET_TARGET, 1, 0, SW_OPEN);
    dir_tab[22] = row(CMD_RAMP, 1, 0, SW_OPEN);
    dir_tab[23] = row(CMD_SET_TARGET, 0, 55, SW_OPEN);
    dir_tab[24] = row(CMD_RAMP, 0, 0, SW_OPEN);
    dir_tab[25] = row(CMD_STOP, 0, 0, SW_OPEN);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < DIRECTED_ROWS; n++) issue(dir_tab[n]);

    // Register phases; motor state carries across, so a new period shows up
    // on the next ramp that moves a motor.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      cmd_valid <= 1'b0;
      drain();
      case (ph)
        0: begin step_w = 16'd1;     period_w = 16'd0;     end
        1: begin step_w = 16'd10;    period_w = 16'hFFFF;  end
        2: begin step_w = 16'd0;     period_w = 16'd100;   end  // step dropped
        3: begin step_w = 16'hA5F3;  period_w = 16'($urandom);  end  // low nibble 3
        4: begin step_w = 16'd15;    period_w = 16'd1;     end  // step dropped
        5: begin step_w = 16'd11;    period_w = 16'd1000;  end  // step dropped
        default: begin step_w = 16'd7; period_w = 16'($urandom); end
      endcase
      program_regs(step_w, period_w);
      if (ph == 0) squeeze_go = 1'b1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) issue(rand_row());
    end

    cmd_valid <= 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (drive_expect_q.size() != 0) log_error("expected results never arrived");

    if (err_count == 0) begin
      $display("tb_dual_hbridge_ramp_pwm_core: clean");
    end else begin
      $display("tb_dual_hbridge_ramp_pwm_core: errors");
    end
    $finish;
  end

endmodule
